### src/tms_pkg.sv
// ----------------------------------------------------------------------------
// Tactile matrix scan package
// Shared sizes, operation codes, phase type and request structures for the
// scan sequencer and its submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package tms_pkg;

  // Frame size and derived widths.
  localparam int NUM_VALUES = 16;
  localparam int IDX_W      = $clog2(NUM_VALUES);
  localparam int CNT_W      = $clog2(NUM_VALUES + 1);
  localparam int COLNUM_W   = CNT_W - 2;
  localparam int ADDR_W     = IDX_W + 1;
  localparam int RAM_DEPTH  = 2 * NUM_VALUES;

  // Fixed field widths.
  localparam int OP_W     = 2;
  localparam int SAMPLE_W = 12;
  localparam int RIDX_W   = 4;
  localparam int LINES_W  = 4;
  localparam int CH_W     = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ    = 2'd2;

  // Column lines after reset: every line high.
  localparam logic [LINES_W-1:0] LINES_IDLE = '1;

  typedef enum logic [1:0] {
    PH_SETUP     = 2'd0,
    PH_SAMPLING  = 2'd1,
    PH_WAITING   = 2'd2,
    PH_COMPLETED = 2'd3
  } phase_t;

  // Result fields produced by the controller for one request.
  typedef struct packed {
    phase_t              phase;
    logic [LINES_W-1:0]  column_drive;
    logic [CH_W-1:0]     adc_channel;
    logic                sample_taken;
    logic                frame_published;
    logic                is_read;
  } result_t;

  // Buffer RAM port requests from the controller.
  typedef struct packed {
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [SAMPLE_W-1:0] wr_data;
    logic [ADDR_W-1:0]   rd_addr;
  } ram_req_t;

  // Column pattern for a sample count: the column count/4 is grounded,
  // and a column past the last line leaves all lines high.
  function automatic logic [LINES_W-1:0] column_pattern(input logic [CNT_W-1:0] count);
    logic [COLNUM_W-1:0] col;
    logic [LINES_W-1:0]  pat;
    col = count[CNT_W-1:2];
    pat = LINES_IDLE;
    for (int i = 0; i < LINES_W; i++) begin
      if (32'(col) == i) begin
        pat[i] = 1'b0;
      end
    end
    return pat;
  endfunction

endpackage

`default_nettype wire

### src/tms_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tms_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while rd_en is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

### src/tms_ctrl.sv
// ----------------------------------------------------------------------------
// Scan controller
// Holds the scan phase, sample count, consumer flag, column lines and the
// ping-pong bank pointer, and decodes each request into result fields and
// buffer RAM accesses.
// ----------------------------------------------------------------------------
`default_nettype none

module tms_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic [tms_pkg::OP_W-1:0]      operation,
  input  wire logic [tms_pkg::SAMPLE_W-1:0]  adc_sample,
  input  wire logic [tms_pkg::RIDX_W-1:0]    read_index,
  output tms_pkg::result_t                   result,
  output tms_pkg::ram_req_t                  ram_req
);

  import tms_pkg::*;

  phase_t             phase_r,    phase_nxt;
  logic [CNT_W-1:0]   count_r,    count_nxt;
  logic               consumed_r, consumed_nxt;
  logic [LINES_W-1:0] lines_r,    lines_nxt;
  logic               bank_r,     bank_nxt;
  logic               has_frame_r, has_frame_nxt;

  logic [CNT_W-1:0]   count_inc;
  logic               frame_full;
  logic               publish;
  logic               capture;
  logic               read_ok;

  assign count_inc  = CNT_W'(count_r + 1'b1);
  assign frame_full = (count_r >= CNT_W'(NUM_VALUES));
  assign read_ok    = ({28'd0, read_index} < 32'(NUM_VALUES));

  // Decode of the advance step in the current phase.
  always_comb begin
    publish = 1'b0;
    capture = 1'b0;
    if (operation == OP_ADVANCE) begin
      case (phase_r)
        PH_SAMPLING: begin
          publish = frame_full && consumed_r;
          capture = !frame_full;
        end
        PH_WAITING: begin
          publish = consumed_r;
        end
        default: begin
        end
      endcase
    end
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (operation == OP_ADVANCE) begin
      case (phase_r)
        PH_SETUP: begin
          phase_nxt = PH_SAMPLING;
        end
        PH_SAMPLING: begin
          if (publish) begin
            phase_nxt = PH_COMPLETED;
          end else if (frame_full) begin
            phase_nxt = PH_WAITING;
          end else if (count_inc[1:0] == 2'd0 && count_inc < CNT_W'(NUM_VALUES)) begin
            phase_nxt = PH_SETUP;
          end
        end
        PH_WAITING: begin
          if (publish) begin
            phase_nxt = PH_COMPLETED;
          end
        end
        default: begin
          phase_nxt = PH_SETUP;
        end
      endcase
    end
  end

  // Remaining state updates.
  always_comb begin
    count_nxt     = count_r;
    consumed_nxt  = consumed_r;
    lines_nxt     = lines_r;
    bank_nxt      = bank_r;
    has_frame_nxt = has_frame_r;
    if (operation == OP_ADVANCE) begin
      if (phase_r == PH_SETUP) begin
        lines_nxt = column_pattern(count_r);
      end
      if (phase_r == PH_COMPLETED) begin
        count_nxt = '0;
      end
      if (capture) begin
        count_nxt = count_inc;
      end
      // Publishing flips the ping-pong pointer: the captured bank becomes
      // the stable bank.
      if (publish) begin
        consumed_nxt  = 1'b0;
        bank_nxt      = !bank_r;
        has_frame_nxt = 1'b1;
      end
    end else if (operation == OP_RELEASE) begin
      consumed_nxt = 1'b1;
    end
  end

  // Result fields and RAM accesses.
  always_comb begin
    result.phase           = phase_nxt;
    result.column_drive    = lines_nxt;
    result.adc_channel     = capture ? count_r[1:0] : '0;
    result.sample_taken    = capture;
    result.frame_published = publish;
    result.is_read         = (operation == OP_READ) && read_ok && has_frame_r;

    ram_req.wr_en   = accept && capture;
    ram_req.wr_addr = {!bank_r, count_r[IDX_W-1:0]};
    ram_req.wr_data = adc_sample;
    ram_req.rd_addr = {bank_r, IDX_W'(read_index)};
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SETUP;
      count_r     <= '0;
      consumed_r  <= 1'b1;
      lines_r     <= LINES_IDLE;
      bank_r      <= 1'b0;
      has_frame_r <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      consumed_r  <= consumed_nxt;
      lines_r     <= lines_nxt;
      bank_r      <= bank_nxt;
      has_frame_r <= has_frame_nxt;
    end
  end

endmodule

`default_nettype wire

### src/tactile_matrix_scan_sequencer.sv
// ----------------------------------------------------------------------------
// Tactile matrix scan sequencer
// An accepted request's result is in the output register in the next cycle.
// Throughput: one request per cycle unless out_stall holds a valid result,
// limited by the single output register and the buffer RAM's one read port.
// The capture and stable buffers share one RAM as two banks; a published
// frame flips the bank pointer. Reset is synchronous: phase setup, count
// zero, frame released, lines high, stable entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tactile_matrix_scan_sequencer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tms_pkg::OP_W-1:0]      in_operation,
  input  wire logic [tms_pkg::SAMPLE_W-1:0]  in_adc_sample,
  input  wire logic [tms_pkg::RIDX_W-1:0]    in_read_index,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_phase,
  output logic [tms_pkg::LINES_W-1:0]        out_column_drive,
  output logic [tms_pkg::CH_W-1:0]           out_adc_channel,
  output logic                               out_sample_taken,
  output logic                               out_frame_published,
  output logic [tms_pkg::SAMPLE_W-1:0]       out_read_data
);

  import tms_pkg::*;

  logic                in_accept;
  result_t             result;
  ram_req_t            ram_req;
  logic [SAMPLE_W-1:0] ram_q;

  logic    out_valid_r, out_valid_nxt;
  result_t res_r;

  // A new request enters whenever the output register is free or drains.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  tms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .operation  (in_operation),
    .adc_sample (in_adc_sample),
    .read_index (in_read_index),
    .result     (result),
    .ram_req    (ram_req)
  );

  // Capture and stable banks; read data lines up with the output register.
  tms_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RAM_DEPTH)
  ) u_buf_ram (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (in_accept),
    .rd_addr (ram_req.rd_addr),
    .rd_data (ram_q)
  );

  // Output valid tracking.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_phase           = res_r.phase;
  assign out_column_drive    = res_r.column_drive;
  assign out_adc_channel     = res_r.adc_channel;
  assign out_sample_taken    = res_r.sample_taken;
  assign out_frame_published = res_r.frame_published;
  assign out_read_data       = res_r.is_read ? ram_q : '0;

  // A published frame always leaves the block in the completed phase.
  a_publish_completed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.frame_published |-> res_r.phase == PH_COMPLETED)
    else $error("frame published outside completed phase");

  // One step never both captures a sample and publishes a frame.
  a_capture_xor_publish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.sample_taken && res_r.frame_published))
    else $error("capture and publish in one step");

  // A captured sample leaves the block sampling or back in set-up.
  a_capture_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.sample_taken |->
      (res_r.phase == PH_SAMPLING || res_r.phase == PH_SETUP))
    else $error("sample captured in wrong phase");

  // Every accepted request shows up in the output register next cycle.
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted request produced no result");

endmodule

`default_nettype wire
